>>> hdl/assert_macros.svh
// Assertion macros shared by the ARP resolution engine RTL.
// Each use expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ARE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define ARE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/are_pkg.sv
// Shared types and constants of the ARP resolution engine.
// No dependencies; used by are_ctrl, are_dp and arp_resolution_engine.
`default_nettype none

package are_pkg;

  localparam int unsigned CacheEntriesDef   = 16;
  localparam int unsigned PendingEntriesDef = 16;
  localparam int unsigned QueueDepthDef     = 16;

  // at most this many datagrams leave on one reply
  localparam int unsigned MaxRelease = 16;
  localparam int unsigned RelCntW    = $clog2(MaxRelease + 1);

  localparam logic [1:0] ActSend = 2'd0;
  localparam logic [1:0] ActRecv = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;

  localparam logic [1:0] KindIpv4     = 2'd0;
  localparam logic [1:0] KindArpReq   = 2'd1;
  localparam logic [1:0] KindArpReply = 2'd2;
  localparam logic [1:0] KindDeliver  = 2'd3;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgOwnIp  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnMac = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMapTmo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgReqTmo = 2'd3;

  localparam logic [31:0] MapTmoRst = 32'd30000;
  localparam logic [31:0] ReqTmoRst = 32'd5000;

  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [15:0] EthArp    = 16'h0806;
  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [15:0] OpReply   = 16'd2;
  localparam logic [47:0] BcastMac  = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic load;
    logic exec;
    logic victim_step;
    logic arp_act;
    logic rel_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic arp_frame;
    logic learn_full;
    logic victim_done;
    logic arp_release;
    logic rel_done;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/arp_resolution_engine.sv
// Top level of the ARP resolution engine: controller plus datapath.
// Depends on are_pkg, are_ctrl, are_dp.
//
//   channel | ports                         | transfer when
//   input   | in_valid / in_ready, in_*     | in_valid & in_ready
//   result  | out_valid / out_ready, out_*  | out_valid & out_ready
//   config  | cfg_valid / cfg_ready, cfg_*  | cfg_valid (cfg_ready is tied high)
//
// Send, IPv4 delivery and tick items pass through input capture, then the
// parallel compares over the cache and pending table. ARP items then take
// an action step, preceded by the oldest-entry scan over the cache when the
// cache is full and the sender IP is new; a reply then walks the queue,
// releasing matching datagrams and compacting the rest in arrival order.
// Any cycle that must write a result waits while the result register is full.
// Reset is synchronous; all tables read as empty right after it.
`default_nettype none

module arp_resolution_engine #(
  parameter int unsigned CACHE_ENTRIES   = are_pkg::CacheEntriesDef,
  parameter int unsigned PENDING_ENTRIES = are_pkg::PendingEntriesDef,
  parameter int unsigned QUEUE_DEPTH     = are_pkg::QueueDepthDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_action,
  input  wire logic [31:0]                  in_next_hop_ip,
  input  wire logic [15:0]                  in_datagram_tag,
  input  wire logic [47:0]                  in_dst_mac,
  input  wire logic [15:0]                  in_ether_type,
  input  wire logic                         in_payload_ok,
  input  wire logic [15:0]                  in_arp_opcode,
  input  wire logic [31:0]                  in_arp_sender_ip,
  input  wire logic [47:0]                  in_arp_sender_mac,
  input  wire logic [31:0]                  in_arp_target_ip,
  input  wire logic [31:0]                  in_elapsed_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_kind,
  output logic [47:0]                       out_frame_dst_mac,
  output logic [31:0]                       out_arp_query_ip,
  output logic [15:0]                       out_tag,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [are_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [47:0]                  cfg_data
);

  are_pkg::ctrl_cmd_t  cmd;
  are_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  are_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  are_dp #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES),
    .QUEUE_DEPTH     (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_action         (in_action),
    .in_next_hop_ip    (in_next_hop_ip),
    .in_datagram_tag   (in_datagram_tag),
    .in_dst_mac        (in_dst_mac),
    .in_ether_type     (in_ether_type),
    .in_payload_ok     (in_payload_ok),
    .in_arp_opcode     (in_arp_opcode),
    .in_arp_sender_ip  (in_arp_sender_ip),
    .in_arp_sender_mac (in_arp_sender_mac),
    .in_arp_target_ip  (in_arp_target_ip),
    .in_elapsed_ms     (in_elapsed_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_frame_dst_mac (out_frame_dst_mac),
    .out_arp_query_ip  (out_arp_query_ip),
    .out_tag           (out_tag),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

>>> hdl/are_ctrl.sv
// Controller FSM of the ARP resolution engine.
// Depends on are_pkg; drives commands into are_dp, reads its status.
`default_nettype none

module are_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  are_pkg::dp_status_t     st,
  output are_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_VICTIM = 5'b00100,
    S_ARP    = 5'b01000,
    S_REL    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.exec = 1'b1;
          if (st.arp_frame) begin
            state_nxt = st.learn_full ? S_VICTIM : S_ARP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_VICTIM: begin
        cmd.victim_step = 1'b1;
        if (st.victim_done) begin
          state_nxt = S_ARP;
        end
      end
      S_ARP: begin
        if (st.out_free) begin
          cmd.arp_act = 1'b1;
          state_nxt   = st.arp_release ? S_REL : S_IDLE;
        end
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        if (st.rel_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/are_dp.sv
// Datapath of the ARP resolution engine: config, cache, pending table,
// datagram queue and result register. Depends on are_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module are_dp #(
  parameter int unsigned CACHE_ENTRIES   = are_pkg::CacheEntriesDef,
  parameter int unsigned PENDING_ENTRIES = are_pkg::PendingEntriesDef,
  parameter int unsigned QUEUE_DEPTH     = are_pkg::QueueDepthDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  are_pkg::ctrl_cmd_t                cmd,
  output are_pkg::dp_status_t               st,
  input  wire logic                         cfg_valid,
  input  wire logic [are_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [47:0]                  cfg_data,
  input  wire logic [1:0]                   in_action,
  input  wire logic [31:0]                  in_next_hop_ip,
  input  wire logic [15:0]                  in_datagram_tag,
  input  wire logic [47:0]                  in_dst_mac,
  input  wire logic [15:0]                  in_ether_type,
  input  wire logic                         in_payload_ok,
  input  wire logic [15:0]                  in_arp_opcode,
  input  wire logic [31:0]                  in_arp_sender_ip,
  input  wire logic [47:0]                  in_arp_sender_mac,
  input  wire logic [31:0]                  in_arp_target_ip,
  input  wire logic [31:0]                  in_elapsed_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_kind,
  output logic [47:0]                       out_frame_dst_mac,
  output logic [31:0]                       out_arp_query_ip,
  output logic [15:0]                       out_tag,
  output logic                              out_last
);

  localparam int unsigned CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CCW = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RCW = are_pkg::RelCntW;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // config
  logic [31:0] own_ip_r, map_tmo_r, req_tmo_r;
  logic [47:0] own_mac_r;

  // item under work
  logic [1:0]  act_r;
  logic [31:0] nh_ip_r, sip_r, tip_r, ms_r;
  logic [15:0] tag_r, etype_r, op_r;
  logic [47:0] dst_r, smac_r;
  logic        ok_r;

  // tables
  logic        c_valid_r [CACHE_ENTRIES];
  logic [31:0] c_ip_r    [CACHE_ENTRIES];
  logic [47:0] c_mac_r   [CACHE_ENTRIES];
  logic [31:0] c_age_r   [CACHE_ENTRIES];
  logic [31:0] c_age_tick[CACHE_ENTRIES];
  logic        p_valid_r [PENDING_ENTRIES];
  logic [31:0] p_ip_r    [PENDING_ENTRIES];
  logic [31:0] p_age_r   [PENDING_ENTRIES];
  logic [31:0] p_age_tick[PENDING_ENTRIES];
  logic [31:0] q_ip_r    [QUEUE_DEPTH];
  logic [15:0] q_tag_r   [QUEUE_DEPTH];
  logic [QCW-1:0] qcnt_r;

  // victim scan
  logic [CCW-1:0] vcnt_r;
  logic [CIW-1:0] best_idx_r;
  logic [31:0]    best_age_r;

  // release walk
  logic [QCW-1:0] rd_r, wr_r;
  logic [RCW-1:0] rel_cnt_r;
  logic           hold_v_r;
  logic [15:0]    hold_tag_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [47:0] out_mac_r;
  logic [31:0] out_ip_r;
  logic [15:0] out_tag_r;
  logic        out_last_r;

  logic           out_free;
  logic [31:0]    c_key;
  logic           c_hit, c_free_any, p_hit, p_free_any;
  logic [CIW-1:0] c_hit_idx, c_free_idx, learn_idx;
  logic [PIW-1:0] p_free_idx;
  logic           frame_ok, arp_frame, learn_full, victim_done;
  logic           is_send, is_tick, miss_path, learn_we;
  logic           rel_at_end, rel_match, rel_stall, rel_done, rel_go;
  logic [QIW-1:0] rdi;
  logic           emit, e_last;
  logic [1:0]     e_kind;
  logic [47:0]    e_mac;
  logic [31:0]    e_ip;
  logic [15:0]    e_tag;

  assign out_free = !out_valid_r || out_ready;
  assign is_send  = (act_r == are_pkg::ActSend);
  assign is_tick  = (act_r == are_pkg::ActTick);
  assign c_key    = is_send ? nh_ip_r : sip_r;

  // parallel tag compare, lowest index wins
  always_comb begin
    c_hit = 1'b0; c_hit_idx = '0; c_free_any = 1'b0; c_free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      c_age_tick[i] = sat_add(c_age_r[i], ms_r);
      if (c_valid_r[i] && c_ip_r[i] == c_key) begin
        c_hit = 1'b1; c_hit_idx = CIW'(i);
      end
      if (!c_valid_r[i]) begin
        c_free_any = 1'b1; c_free_idx = CIW'(i);
      end
    end
  end

  always_comb begin
    p_hit = 1'b0; p_free_any = 1'b0; p_free_idx = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      p_age_tick[i] = sat_add(p_age_r[i], ms_r);
      if (p_valid_r[i] && p_ip_r[i] == nh_ip_r) p_hit = 1'b1;
      if (!p_valid_r[i]) begin
        p_free_any = 1'b1; p_free_idx = PIW'(i);
      end
    end
  end

  assign frame_ok    = (dst_r == are_pkg::BcastMac || dst_r == own_mac_r) && ok_r;
  assign arp_frame   = (act_r == are_pkg::ActRecv) && frame_ok && (etype_r == are_pkg::EthArp);
  assign learn_full  = !c_hit && !c_free_any;
  assign victim_done = (vcnt_r == CCW'(CACHE_ENTRIES));
  assign miss_path   = cmd.exec && is_send && !c_hit;
  assign learn_we    = (cmd.exec && arp_frame && !learn_full)
                     || (cmd.victim_step && victim_done);
  assign learn_idx   = cmd.victim_step ? best_idx_r : (c_hit ? c_hit_idx : c_free_idx);

  assign rdi        = rd_r[QIW-1:0];
  assign rel_at_end = (rd_r == qcnt_r);
  assign rel_match  = (q_ip_r[rdi] == sip_r) && (rel_cnt_r < RCW'(are_pkg::MaxRelease));
  assign rel_stall  = !rel_at_end && rel_match && hold_v_r && !out_free;
  assign rel_done   = rel_at_end && (!hold_v_r || out_free);
  assign rel_go     = cmd.rel_step && !rel_at_end && !rel_stall;

  assign st.out_free    = out_free;
  assign st.arp_frame   = arp_frame;
  assign st.learn_full  = learn_full;
  assign st.victim_done = victim_done;
  assign st.arp_release = (op_r == are_pkg::OpReply);
  assign st.rel_done    = rel_done;

  // result selection
  always_comb begin
    emit = 1'b0; e_kind = are_pkg::KindIpv4; e_mac = '0; e_ip = '0; e_tag = '0;
    e_last = 1'b1;
    if (cmd.exec) begin
      if (is_send) begin
        if (c_hit) begin
          emit = 1'b1; e_mac = c_mac_r[c_hit_idx]; e_tag = tag_r;
        end else if (!p_hit) begin
          emit = 1'b1; e_kind = are_pkg::KindArpReq; e_mac = are_pkg::BcastMac;
          e_ip = nh_ip_r;
        end
      end else if ((act_r == are_pkg::ActRecv) && frame_ok
                   && (etype_r == are_pkg::EthIpv4)) begin
        emit = 1'b1; e_kind = are_pkg::KindDeliver; e_tag = tag_r;
      end
    end else if (cmd.arp_act) begin
      if (op_r == are_pkg::OpRequest && tip_r == own_ip_r) begin
        emit = 1'b1; e_kind = are_pkg::KindArpReply; e_mac = smac_r; e_ip = sip_r;
      end
    end else if (cmd.rel_step && hold_v_r) begin
      e_mac = smac_r; e_tag = hold_tag_r;
      if (rel_at_end) begin
        emit = out_free;
      end else if (rel_match) begin
        emit = out_free; e_last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
      map_tmo_r <= are_pkg::MapTmoRst;
      req_tmo_r <= are_pkg::ReqTmoRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        are_pkg::CfgOwnIp:  own_ip_r  <= cfg_data[31:0];
        are_pkg::CfgOwnMac: own_mac_r <= cfg_data;
        are_pkg::CfgMapTmo: map_tmo_r <= cfg_data[31:0];
        are_pkg::CfgReqTmo: req_tmo_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;        nh_ip_r <= in_next_hop_ip;
      tag_r   <= in_datagram_tag;  dst_r   <= in_dst_mac;
      etype_r <= in_ether_type;    ok_r    <= in_payload_ok;
      op_r    <= in_arp_opcode;    sip_r   <= in_arp_sender_ip;
      smac_r  <= in_arp_sender_mac; tip_r  <= in_arp_target_ip;
      ms_r    <= in_elapsed_ms;
    end
  end

  // cache
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) c_valid_r[i] <= 1'b0;
    end else begin
      if (cmd.exec && is_tick) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (c_valid_r[i] && c_age_tick[i] > map_tmo_r) c_valid_r[i] <= 1'b0;
        end
      end
      if (learn_we) c_valid_r[learn_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_tick) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (c_valid_r[i]) c_age_r[i] <= c_age_tick[i];
      end
    end
    if (learn_we) begin
      c_ip_r[learn_idx]  <= sip_r;
      c_mac_r[learn_idx] <= smac_r;
      c_age_r[learn_idx] <= '0;
    end
  end

  // oldest-entry scan, one entry a cycle, strict compare keeps the lowest index
  always_ff @(posedge clk) begin
    if (cmd.exec && arp_frame && learn_full) begin
      vcnt_r     <= CCW'(1);
      best_idx_r <= '0;
      best_age_r <= c_age_r[0];
    end else if (cmd.victim_step && !victim_done) begin
      vcnt_r <= vcnt_r + CCW'(1);
      if (c_age_r[vcnt_r[CIW-1:0]] > best_age_r) begin
        best_idx_r <= vcnt_r[CIW-1:0];
        best_age_r <= c_age_r[vcnt_r[CIW-1:0]];
      end
    end
  end

  // pending requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PENDING_ENTRIES; i++) p_valid_r[i] <= 1'b0;
    end else if (cmd.exec && is_tick) begin
      for (int i = 0; i < PENDING_ENTRIES; i++) begin
        if (p_valid_r[i] && p_age_tick[i] > req_tmo_r) p_valid_r[i] <= 1'b0;
      end
    end else if (miss_path && !p_hit && p_free_any) begin
      p_valid_r[p_free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_tick) begin
      for (int i = 0; i < PENDING_ENTRIES; i++) begin
        if (p_valid_r[i]) p_age_r[i] <= p_age_tick[i];
      end
    end else if (miss_path && !p_hit && p_free_any) begin
      p_ip_r[p_free_idx]  <= nh_ip_r;
      p_age_r[p_free_idx] <= '0;
    end
  end

  // datagram queue, compacted in arrival order
  always_ff @(posedge clk) begin
    if (miss_path && qcnt_r < QCW'(QUEUE_DEPTH)) begin
      q_ip_r[qcnt_r[QIW-1:0]]  <= nh_ip_r;
      q_tag_r[qcnt_r[QIW-1:0]] <= tag_r;
    end else if (rel_go && !rel_match) begin
      q_ip_r[wr_r[QIW-1:0]]  <= q_ip_r[rdi];
      q_tag_r[wr_r[QIW-1:0]] <= q_tag_r[rdi];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r    <= '0;
      rd_r      <= '0;
      wr_r      <= '0;
      rel_cnt_r <= '0;
      hold_v_r  <= 1'b0;
    end else begin
      if (miss_path && qcnt_r < QCW'(QUEUE_DEPTH)) qcnt_r <= qcnt_r + QCW'(1);
      if (cmd.arp_act) begin
        rd_r <= '0; wr_r <= '0; rel_cnt_r <= '0; hold_v_r <= 1'b0;
      end else if (cmd.rel_step && rel_done) begin
        qcnt_r   <= wr_r;
        hold_v_r <= 1'b0;
      end else if (rel_go) begin
        rd_r <= rd_r + QCW'(1);
        if (rel_match) begin
          hold_v_r  <= 1'b1;
          rel_cnt_r <= rel_cnt_r + RCW'(1);
        end else begin
          wr_r <= wr_r + QCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rel_go && rel_match) hold_tag_r <= q_tag_r[rdi];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_mac_r  <= e_mac;
      out_ip_r   <= e_ip;
      out_tag_r  <= e_tag;
      out_last_r <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_frame_dst_mac = out_mac_r;
  assign out_arp_query_ip  = out_ip_r;
  assign out_tag           = out_tag_r;
  assign out_last          = out_last_r;

  `ARE_ASSERT_ALWAYS(a_qcnt_range, qcnt_r <= QCW'(QUEUE_DEPTH), "queue count past depth")
  `ARE_ASSERT_ALWAYS(a_compact_order, wr_r <= rd_r, "compaction write passed read")
  `ARE_ASSERT_ALWAYS(a_rel_limit, rel_cnt_r <= RCW'(are_pkg::MaxRelease), "release count overrun")
  `ARE_ASSERT_IMPLY(a_emit_slot, emit, out_free, "result written over an untaken one")

endmodule

`default_nettype wire

>>> tb/sv/arp_checker.sv
// Checker for the ARP resolution engine: watches the input, config and result
// channels, predicts the result stream and compares it. Depends on are_pkg.
`default_nettype none

module arp_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [1:0]                  in_action,
  input  wire logic [31:0]                 in_next_hop_ip,
  input  wire logic [15:0]                 in_datagram_tag,
  input  wire logic [47:0]                 in_dst_mac,
  input  wire logic [15:0]                 in_ether_type,
  input  wire logic                        in_payload_ok,
  input  wire logic [15:0]                 in_arp_opcode,
  input  wire logic [31:0]                 in_arp_sender_ip,
  input  wire logic [47:0]                 in_arp_sender_mac,
  input  wire logic [31:0]                 in_arp_target_ip,
  input  wire logic [31:0]                 in_elapsed_ms,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [1:0]                  out_kind,
  input  wire logic [47:0]                 out_frame_dst_mac,
  input  wire logic [31:0]                 out_arp_query_ip,
  input  wire logic [15:0]                 out_tag,
  input  wire logic                        out_last,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [are_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [47:0]                 cfg_data,
  output int unsigned                      fail_count,
  output int unsigned                      frames_waiting
);

  localparam int NCache = are_pkg::CacheEntriesDef;
  localparam int NPend  = are_pkg::PendingEntriesDef;
  localparam int NQueue = are_pkg::QueueDepthDef;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] tag;
    logic        last;
  } frame_cmd_t;

  frame_cmd_t cmd_q[$];
  frame_cmd_t step_cmds[$];

  logic [31:0] own_ip, map_tmo, req_tmo;
  logic [47:0] own_mac;

  logic        c_vld [NCache];
  logic [31:0] c_ip  [NCache];
  logic [47:0] c_mac [NCache];
  logic [31:0] c_age [NCache];
  logic        p_vld [NPend];
  logic [31:0] p_ip  [NPend];
  logic [31:0] p_age [NPend];
  logic        q_vld [NQueue];
  logic [31:0] q_ip  [NQueue];
  logic [15:0] q_tag [NQueue];

  function automatic logic [31:0] age_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void push_cmd(logic [1:0] k, logic [47:0] m, logic [31:0] ip,
                                   logic [15:0] tag);
    frame_cmd_t c;
    if (step_cmds.size() >= are_pkg::MaxRelease) return;
    c.kind = k; c.mac = m; c.ip = ip; c.tag = tag; c.last = 1'b0;
    step_cmds.push_back(c);
  endfunction

  function automatic void learn_map(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = -1;
    for (int i = 0; i < NCache; i++)
      if (slot < 0 && c_vld[i] && c_ip[i] == ip) slot = i;
    for (int i = 0; i < NCache; i++)
      if (slot < 0 && !c_vld[i]) slot = i;
    if (slot < 0) begin
      // cache full: evict oldest, lowest index wins a tie
      slot = 0;
      for (int i = 1; i < NCache; i++)
        if (c_age[i] > c_age[slot]) slot = i;
    end
    c_vld[slot] = 1'b1; c_ip[slot] = ip; c_mac[slot] = mac; c_age[slot] = '0;
  endfunction

  function automatic void send_dgram(logic [31:0] ip, logic [15:0] tag);
    bit placed;
    for (int i = 0; i < NCache; i++)
      if (c_vld[i] && c_ip[i] == ip) begin
        push_cmd(are_pkg::KindIpv4, c_mac[i], '0, tag);
        return;
      end
    placed = 1'b0;
    for (int i = 0; i < NQueue; i++)
      if (!placed && !q_vld[i]) begin
        q_vld[i] = 1'b1; q_ip[i] = ip; q_tag[i] = tag; placed = 1'b1;
      end
    for (int i = 0; i < NPend; i++)
      if (p_vld[i] && p_ip[i] == ip) return;
    push_cmd(are_pkg::KindArpReq, are_pkg::BcastMac, ip, '0);
    placed = 1'b0;
    for (int i = 0; i < NPend; i++)
      if (!placed && !p_vld[i]) begin
        p_vld[i] = 1'b1; p_ip[i] = ip; p_age[i] = '0; placed = 1'b1;
      end
  endfunction

  function automatic void flush_queue(logic [31:0] ip, logic [47:0] mac);
    int wr;
    wr = 0;
    for (int rd = 0; rd < NQueue; rd++) begin
      if (!q_vld[rd]) break;
      if (q_ip[rd] == ip && step_cmds.size() < are_pkg::MaxRelease) begin
        push_cmd(are_pkg::KindIpv4, mac, '0, q_tag[rd]);
        continue;
      end
      q_ip[wr] = q_ip[rd]; q_tag[wr] = q_tag[rd]; q_vld[wr] = 1'b1;
      wr++;
    end
    for (int rd = wr; rd < NQueue; rd++) begin
      q_vld[rd] = 1'b0; q_ip[rd] = '0; q_tag[rd] = '0;
    end
  endfunction

  function automatic void rx_frame();
    if (in_dst_mac != are_pkg::BcastMac && in_dst_mac != own_mac) return;
    if (!in_payload_ok) return;
    if (in_ether_type == are_pkg::EthIpv4) begin
      push_cmd(are_pkg::KindDeliver, '0, '0, in_datagram_tag);
    end else if (in_ether_type == are_pkg::EthArp) begin
      learn_map(in_arp_sender_ip, in_arp_sender_mac);
      if (in_arp_opcode == are_pkg::OpRequest && in_arp_target_ip == own_ip)
        push_cmd(are_pkg::KindArpReply, in_arp_sender_mac, in_arp_sender_ip, '0);
      else if (in_arp_opcode == are_pkg::OpReply)
        flush_queue(in_arp_sender_ip, in_arp_sender_mac);
    end
  endfunction

  function automatic void age_tables(logic [31:0] ms);
    for (int i = 0; i < NCache; i++)
      if (c_vld[i]) begin
        c_age[i] = age_add(c_age[i], ms);
        if (c_age[i] > map_tmo) c_vld[i] = 1'b0;
      end
    for (int i = 0; i < NPend; i++)
      if (p_vld[i]) begin
        p_age[i] = age_add(p_age[i], ms);
        if (p_age[i] > req_tmo) p_vld[i] = 1'b0;
      end
  endfunction

  assign frames_waiting = int'(cmd_q.size());

  always @(posedge clk) begin
    frame_cmd_t got, exp_c;
    if (!rst_n) begin
      own_ip = '0; own_mac = '0;
      map_tmo = are_pkg::MapTmoRst; req_tmo = are_pkg::ReqTmoRst;
      for (int i = 0; i < NCache; i++) begin
        c_vld[i] = 1'b0; c_ip[i] = '0; c_mac[i] = '0; c_age[i] = '0;
      end
      for (int i = 0; i < NPend; i++) begin
        p_vld[i] = 1'b0; p_ip[i] = '0; p_age[i] = '0;
      end
      for (int i = 0; i < NQueue; i++) begin
        q_vld[i] = 1'b0; q_ip[i] = '0; q_tag[i] = '0;
      end
      cmd_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          are_pkg::CfgOwnIp:  own_ip  = cfg_data[31:0];
          are_pkg::CfgOwnMac: own_mac = cfg_data;
          are_pkg::CfgMapTmo: map_tmo = cfg_data[31:0];
          are_pkg::CfgReqTmo: req_tmo = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_cmds.delete();
        case (in_action)
          are_pkg::ActSend: send_dgram(in_next_hop_ip, in_datagram_tag);
          are_pkg::ActRecv: rx_frame();
          are_pkg::ActTick: age_tables(in_elapsed_ms);
          default: ;
        endcase
        if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
        foreach (step_cmds[i]) cmd_q.push_back(step_cmds[i]);
      end
      if (out_valid && out_ready) begin
        got = '{out_kind, out_frame_dst_mac, out_arp_query_ip, out_tag, out_last};
        if (cmd_q.size() == 0) begin
          $error("unexpected result transfer: kind %0d tag %h", out_kind, out_tag);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = cmd_q.pop_front();
          if (got != exp_c) begin
            fail_count <= fail_count + 1;
            if (got.kind != exp_c.kind)
              $error("kind: expected %0d, got %0d", exp_c.kind, got.kind);
            if (got.mac != exp_c.mac)
              $error("frame_dst_mac: expected %h, got %h", exp_c.mac, got.mac);
            if (got.ip != exp_c.ip)
              $error("arp_query_ip: expected %h, got %h", exp_c.ip, got.ip);
            if (got.tag != exp_c.tag)
              $error("out_tag: expected %h, got %h", exp_c.tag, got.tag);
            if (got.last != exp_c.last)
              $error("last: expected %0d, got %0d", exp_c.last, got.last);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench top for arp_resolution_engine: clock, reset, config writes and
// stimulus; checking is done by arp_checker. Depends on are_pkg.
`default_nettype none

module tb_top;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0]  in_action;
  logic [31:0] in_next_hop_ip, in_arp_sender_ip, in_arp_target_ip, in_elapsed_ms;
  logic [15:0] in_datagram_tag, in_ether_type, in_arp_opcode;
  logic [47:0] in_dst_mac, in_arp_sender_mac;
  logic        in_payload_ok;
  logic out_valid, out_ready, out_last;
  logic [1:0]  out_kind;
  logic [47:0] out_frame_dst_mac;
  logic [31:0] out_arp_query_ip;
  logic [15:0] out_tag;
  logic cfg_valid, cfg_ready;
  logic [are_pkg::CfgIdxW-1:0] cfg_index;
  logic [47:0] cfg_data;
  int unsigned fail_count, frames_waiting;

  int send_idle, recv_idle;
  logic [31:0] cur_ip;
  logic [47:0] cur_mac;
  logic [31:0] ip_pool [24];

  arp_resolution_engine u_top (.*);
  arp_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [47:0] rnd48();
    return {16'($urandom), $urandom};
  endfunction

  task automatic put(logic [1:0] act, logic [31:0] nh, logic [15:0] tag, logic [47:0] dst,
                     logic [15:0] et, logic ok, logic [15:0] op, logic [31:0] sip,
                     logic [47:0] smac, logic [31:0] tip, logic [31:0] ms);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act; in_next_hop_ip <= nh; in_datagram_tag <= tag; in_dst_mac <= dst;
    in_ether_type <= et; in_payload_ok <= ok; in_arp_opcode <= op;
    in_arp_sender_ip <= sip; in_arp_sender_mac <= smac; in_arp_target_ip <= tip;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_dg(logic [31:0] ip, logic [15:0] tag);
    put(are_pkg::ActSend, ip, tag, rnd48(), 16'($urandom), 1'($urandom), 16'($urandom),
        $urandom, rnd48(), $urandom, $urandom);
  endtask

  task automatic frame(logic [47:0] dst, logic [15:0] et, logic ok, logic [15:0] op,
                       logic [31:0] sip, logic [47:0] smac, logic [31:0] tip);
    put(are_pkg::ActRecv, $urandom, 16'($urandom), dst, et, ok, op, sip, smac, tip,
        $urandom);
  endtask

  task automatic tick(logic [31:0] ms);
    put(are_pkg::ActTick, $urandom, 16'($urandom), rnd48(), 16'($urandom), 1'($urandom),
        16'($urandom), $urandom, rnd48(), $urandom, ms);
  endtask

  task automatic cfg_write(logic [are_pkg::CfgIdxW-1:0] idx, logic [47:0] data);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] ip, logic [47:0] mac, logic [31:0] mt,
                           logic [31:0] rt);
    cur_ip = ip; cur_mac = mac;
    cfg_write(are_pkg::CfgOwnIp, {16'($urandom), ip});
    cfg_write(are_pkg::CfgOwnMac, mac);
    cfg_write(are_pkg::CfgMapTmo, {16'h0, mt});
    cfg_write(are_pkg::CfgReqTmo, {16'hFFFF, rt});
    cfg_valid <= 1'b0;
  endtask

  // wait until the engine is idle and every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!(in_ready && !out_valid && frames_waiting == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [47:0] pick_dst();
    int r;
    r = $urandom_range(99);
    if (r < 45) return cur_mac;
    if (r < 90) return are_pkg::BcastMac;
    return rnd48();
  endfunction

  task automatic random_item();
    int r;
    logic [31:0] ip;
    ip = ip_pool[$urandom_range(23)];
    r = $urandom_range(99);
    if (r < 3) begin
      // 17 sends to one address (overflowing the queue on a cache miss), then one ARP reply from it
      for (int i = 0; i < 17; i++) send_dg(ip, 16'($urandom));
      frame(pick_dst(), are_pkg::EthArp, 1'b1, are_pkg::OpReply, ip, rnd48(), $urandom);
    end else if (r < 33) begin
      send_dg(ip, 16'($urandom));
    end else if (r < 58) begin
      frame(pick_dst(), are_pkg::EthArp, $urandom_range(9) != 0,
            ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2)),
            ip, rnd48(), $urandom_range(1) ? cur_ip : ip_pool[$urandom_range(23)]);
    end else if (r < 68) begin
      frame(pick_dst(), are_pkg::EthIpv4, $urandom_range(9) != 0, 16'($urandom),
            $urandom, rnd48(), $urandom);
    end else if (r < 83) begin
      tick(($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(3000)));
    end else begin
      put(2'($urandom), $urandom, 16'($urandom), ($urandom_range(1)) ? rnd48() : pick_dst(),
          16'($urandom), 1'($urandom), 16'($urandom), $urandom, rnd48(), $urandom,
          $urandom);
    end
  endtask

  initial begin
    logic [31:0] ipa, ipb, ipc;
    rst_n = 0; in_valid = 0; cfg_valid = 0;
    in_action = '0; in_next_hop_ip = '0; in_datagram_tag = '0; in_dst_mac = '0;
    in_ether_type = '0; in_payload_ok = 0; in_arp_opcode = '0; in_arp_sender_ip = '0;
    in_arp_sender_mac = '0; in_arp_target_ip = '0; in_elapsed_ms = '0;
    cfg_index = '0; cfg_data = '0;
    send_idle = 0; recv_idle = 0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure($urandom, rnd48(), 32'd30000, 32'd5000);
    ipa = ip_pool[0]; ipb = ip_pool[1]; ipc = ip_pool[2];
    send_dg(ipa, 16'h0000);
    send_dg(ipa, 16'hFFFF);
    send_dg(ipb, 16'h1234);
    frame(are_pkg::BcastMac, are_pkg::EthArp, 1'b1, are_pkg::OpRequest, ipc, rnd48(),
          cur_ip);
    send_dg(ipc, 16'hABCD);
    frame(cur_mac, are_pkg::EthArp, 1'b1, are_pkg::OpReply, ipa, 48'hFFFF_FFFF_FFFF,
          32'h0);
    send_dg(ipa, 16'h5A5A);
    frame(cur_mac, are_pkg::EthIpv4, 1'b1, '0, '0, '0, '0);
    frame(are_pkg::BcastMac, are_pkg::EthIpv4, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, '0,
          32'hFFFF_FFFF);
    frame(rnd48(), are_pkg::EthIpv4, 1'b1, '0, '0, '0, '0);
    frame(cur_mac, are_pkg::EthIpv4, 1'b0, '0, '0, '0, '0);
    frame(cur_mac, are_pkg::EthArp, 1'b0, are_pkg::OpReply, ipb, rnd48(), cur_ip);
    frame(cur_mac, 16'hFFFF, 1'b1, are_pkg::OpRequest, ipb, rnd48(), cur_ip);
    frame(cur_mac, are_pkg::EthArp, 1'b1, 16'd3, ipb, rnd48(), cur_ip);
    frame(cur_mac, are_pkg::EthArp, 1'b1, are_pkg::OpReply, ipb, 48'h0, 32'h0);
    put(2'd3, ipa, 16'h1, cur_mac, are_pkg::EthArp, 1'b1, are_pkg::OpReply, ipa, rnd48(),
        cur_ip, 32'd0);
    tick(32'd0);
    tick(32'd30000);
    send_dg(ipc, 16'h0001);
    tick(32'hFFFF_FFFF);
    tick(32'hFFFF_FFFF);
    send_dg(ipc, 16'h0002);
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 17 : (p == 1) ? 86 : 0;
      recv_idle = (p == 0) ? 86 : (p == 1) ? 17 : 0;
      case (p)
        0: configure($urandom, rnd48(), 32'd20000, 32'd4000);
        1: configure(32'hFFFF_FFFF, 48'h0, 32'd0, 32'd0);
        default: configure(32'h0, are_pkg::BcastMac, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      endcase
      for (int i = 0; i < 50; i++) random_item();
      drain();
    end

    if (fail_count == 0 && frames_waiting == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
